/* design/huffman_code_builder_defines.svh */
// Assertion macros for the Huffman code builder.
// Used by huffman_code_builder.sv; expects clk and rst_n in scope.
`ifndef HUFFMAN_CODE_BUILDER_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HCB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("huffman_code_builder: check failed");
`define HCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("huffman_code_builder: check failed");
`else
`define HCB_ASSERT_IMPL(lbl, ante, cons)
`define HCB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/hcb_pkg.sv */
// Shared types and fixed widths for the Huffman code builder.
// No dependencies.
`default_nettype none
package hcb_pkg;
    localparam int SYM_W  = 8;
    localparam int FREQ_W = 16;
    localparam int CODE_W = 31;
    localparam int LEN_W  = 5;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [FREQ_W-1:0] frequency;
        logic              last_symbol;
    } hcb_in_t;

    typedef struct packed {
        logic [SYM_W-1:0]  code_symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic              last_code;
    } hcb_out_t;
endpackage
`default_nettype wire

/* design/huffman_code_builder.sv */
// Huffman code builder top level: load sequencer, heap engine and tree walker.
// Depends on hcb_pkg, hcb_ram and huffman_code_builder_defines.svh.
//
// Usage: symbol/frequency pairs arrive on the in channel (valid/ready), one
// transfer per cycle while loading. Entries past MAX_SYMBOLS are dropped. The
// transfer carrying last_symbol starts the build; in_ready stays low until
// every code has been handed to the out channel. Codes leave one per leaf in
// depth-first order, left (bit 0) before right (bit 1); last_code marks the
// final one. A lone symbol gets code 0 with length 0.
// The build runs on a heap RAM with one write and one read port and
// registered reads. A sift level reads both children, then writes one entry;
// a take of the minimum reads the top and the last entry, then sifts; an
// insert writes the new node's links, then reads and compares each parent.
// The walk pops each entry, then emits a leaf or pushes a node's children.
// The out channel has a single result register; while the receiver stalls,
// the walk holds in place. Reset clears all counts and drops any result in
// flight; RAM contents need no clearing since each entry is written first.
`default_nettype none
`include "huffman_code_builder_defines.svh"
module huffman_code_builder #(
    parameter int MAX_SYMBOLS = 32,
    parameter int FREQ_BITS   = 16,
    parameter int MAX_DEPTH   = 31
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire hcb_pkg::hcb_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output hcb_pkg::hcb_out_t     out_data
);
    import hcb_pkg::*;

    localparam int HA   = $clog2(MAX_SYMBOLS);
    localparam int NA   = HA + 1;
    localparam int WW   = FREQ_BITS + HA;
    localparam int HEW  = WW + NA;
    localparam int SEW  = NA + HA + CODE_W;
    localparam int LKW  = 2 * NA;
    localparam int NODES = 2 * MAX_SYMBOLS;

    localparam logic [4:0] ST_LOAD   = 5'd0;
    localparam logic [4:0] ST_B_RD   = 5'd1;
    localparam logic [4:0] ST_B_GET  = 5'd2;
    localparam logic [4:0] ST_SD_RL  = 5'd3;
    localparam logic [4:0] ST_SD_RR  = 5'd4;
    localparam logic [4:0] ST_SD_DEC = 5'd5;
    localparam logic [4:0] ST_MERGE  = 5'd6;
    localparam logic [4:0] ST_T_RD0  = 5'd7;
    localparam logic [4:0] ST_T_RDL  = 5'd8;
    localparam logic [4:0] ST_T_GO   = 5'd9;
    localparam logic [4:0] ST_NEW    = 5'd10;
    localparam logic [4:0] ST_PU_RD  = 5'd11;
    localparam logic [4:0] ST_PU_CMP = 5'd12;
    localparam logic [4:0] ST_W_INIT = 5'd13;
    localparam logic [4:0] ST_W_POP  = 5'd14;
    localparam logic [4:0] ST_W_GET  = 5'd15;
    localparam logic [4:0] ST_W_LNK  = 5'd16;
    localparam logic [4:0] ST_W_PSH2 = 5'd17;
    localparam logic [4:0] ST_W_EMIT = 5'd18;

    localparam logic [1:0] RET_BUILD = 2'd0;
    localparam logic [1:0] RET_A     = 2'd1;
    localparam logic [1:0] RET_B     = 2'd2;
    localparam logic [1:0] RET_ROOT  = 2'd3;

    // control registers
    logic [4:0]    state_reg,  state_next;
    logic [1:0]    ret_reg,    ret_next;
    logic [HA:0]   loaded_reg, loaded_next;
    logic [HA:0]   n_reg,      n_next;
    logic [HA:0]   cnt_reg,    cnt_next;
    logic [NA-1:0] nodes_reg,  nodes_next;
    logic [HA-1:0] bi_reg,     bi_next;
    logic [HA-1:0] pos_reg,    pos_next;
    logic [HA-1:0] pi_reg,     pi_next;
    logic [HA:0]   sp_reg,     sp_next;
    logic          ov_reg,     ov_next;
    // payload registers
    logic [HEW-1:0] cur_reg, cur_next;
    logic [HEW-1:0] lval_reg, lval_next;
    logic [HEW-1:0] top_reg, top_next;
    logic [HEW-1:0] a_reg, a_next;
    logic [HEW-1:0] b_reg, b_next;
    logic [HEW-1:0] new_reg, new_next;
    logic [SEW-1:0] ent_reg, ent_next;
    hcb_out_t       od_reg, od_next;

    // RAM ports
    logic           sym_we, sym_re;
    logic [HA-1:0]  sym_wa, sym_ra;
    logic [SYM_W-1:0] sym_wd, sym_rd;
    logic           hp_we, hp_re;
    logic [HA-1:0]  hp_wa, hp_ra;
    logic [HEW-1:0] hp_wd, hp_rd;
    logic           lk_we, lk_re;
    logic [NA-1:0]  lk_wa, lk_ra;
    logic [LKW-1:0] lk_wd, lk_rd;
    logic           st_we, st_re;
    logic [HA-1:0]  st_wa, st_ra;
    logic [SEW-1:0] st_wd, st_rd;

    hcb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(SYM_W)) u_sym (
        .clk(clk), .we(sym_we), .waddr(sym_wa), .wdata(sym_wd),
        .re(sym_re), .raddr(sym_ra), .rdata(sym_rd));
    hcb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(HEW)) u_heap (
        .clk(clk), .we(hp_we), .waddr(hp_wa), .wdata(hp_wd),
        .re(hp_re), .raddr(hp_ra), .rdata(hp_rd));
    hcb_ram #(.DEPTH(NODES), .WIDTH(LKW)) u_link (
        .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd),
        .re(lk_re), .raddr(lk_ra), .rdata(lk_rd));
    hcb_ram #(.DEPTH(MAX_SYMBOLS), .WIDTH(SEW)) u_stack (
        .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
        .re(st_re), .raddr(st_ra), .rdata(st_rd));

    // frequency masked to FREQ_BITS and widened to the weight width
    logic [FREQ_W+WW-1:0] freq_ext;
    logic [WW-1:0]        leaf_w;
    always_comb
    begin
        freq_ext = {{WW{1'b0}}, in_data.frequency};
        for (int j = 0; j < WW; j++)
        begin
            leaf_w[j] = (j < FREQ_BITS) ? freq_ext[j] : 1'b0;
        end
    end

    // sift-down child positions and compare
    logic [HA+1:0] l_pos, r_pos;
    logic          l_ok, r_ok;
    logic [WW-1:0] cur_w, l_w, r_w;
    assign l_pos = {1'b0, pos_reg, 1'b1};
    assign r_pos = l_pos + (HA+2)'(1);
    assign l_ok  = l_pos < {1'b0, cnt_reg};
    assign r_ok  = r_pos < {1'b0, cnt_reg};
    assign cur_w = cur_reg[HEW-1:NA];
    assign l_w   = lval_reg[HEW-1:NA];
    assign r_w   = hp_rd[HEW-1:NA];

    // stack entry fields
    logic [NA-1:0]     e_node;
    logic [HA-1:0]     e_depth;
    logic [CODE_W-1:0] e_code;
    assign e_node  = ent_reg[SEW-1:HA+CODE_W];
    assign e_depth = ent_reg[HA+CODE_W-1:CODE_W];
    assign e_code  = ent_reg[CODE_W-1:0];

    logic [HA:0]   load_inc;
    logic [HA-1:0] parent;
    logic [31:0]   len_full;
    assign load_inc = loaded_reg + (HA+1)'(loaded_reg < (HA+1)'(MAX_SYMBOLS));
    assign parent   = HA'((pi_reg - HA'(1)) >> 1);
    assign len_full = (32'(e_depth) > 32'(MAX_DEPTH)) ? 32'(MAX_DEPTH) : 32'(e_depth);

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // sequencer: one RAM access per port per cycle, reads issued in the state
    // before their data is first used, writes never to an entry read in the same cycle
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        loaded_next = loaded_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        nodes_next  = nodes_reg;
        bi_next     = bi_reg;
        pos_next    = pos_reg;
        pi_next     = pi_reg;
        sp_next     = sp_reg;
        cur_next    = cur_reg;
        lval_next   = lval_reg;
        top_next    = top_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        new_next    = new_reg;
        ent_next    = ent_reg;
        od_next     = od_reg;
        ov_next     = ov_reg && !out_ready;
        sym_we = 1'b0; sym_wa = loaded_reg[HA-1:0]; sym_wd = in_data.symbol;
        sym_re = 1'b0; sym_ra = e_node[HA-1:0];
        hp_we  = 1'b0; hp_wa  = pos_reg; hp_wd = cur_reg;
        hp_re  = 1'b0; hp_ra  = l_pos[HA-1:0];
        lk_we  = 1'b0; lk_wa  = nodes_reg; lk_wd = {a_reg[NA-1:0], b_reg[NA-1:0]};
        lk_re  = 1'b0; lk_ra  = e_node;
        st_we  = 1'b0; st_wa  = sp_reg[HA-1:0]; st_wd = ent_reg;
        st_re  = 1'b0; st_ra  = HA'(sp_reg - (HA+1)'(1));

        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (loaded_reg < (HA+1)'(MAX_SYMBOLS))
                    begin
                        sym_we = 1'b1;
                        hp_we  = 1'b1;
                        hp_wa  = loaded_reg[HA-1:0];
                        hp_wd  = {leaf_w, NA'(loaded_reg)};
                    end
                    loaded_next = load_inc;
                    if (in_data.last_symbol)
                    begin
                        n_next     = load_inc;
                        cnt_next   = load_inc;
                        nodes_next = NA'(load_inc);
                        bi_next    = HA'(load_inc >> 1);
                        ret_next   = RET_BUILD;
                        state_next = ST_B_RD;
                    end
                end
            end
            // heap build, sift down from n/2 to 0
            ST_B_RD:
            begin
                hp_re      = 1'b1;
                hp_ra      = bi_reg;
                state_next = ST_B_GET;
            end
            ST_B_GET:
            begin
                cur_next   = hp_rd;
                pos_next   = bi_reg;
                state_next = ST_SD_RL;
            end
            // sift down with the moving entry held in cur_reg
            ST_SD_RL:
            begin
                hp_re      = 1'b1;
                hp_ra      = l_pos[HA-1:0];
                state_next = ST_SD_RR;
            end
            ST_SD_RR:
            begin
                hp_re      = 1'b1;
                hp_ra      = r_pos[HA-1:0];
                lval_next  = hp_rd;
                state_next = ST_SD_DEC;
            end
            ST_SD_DEC:
            begin
                hp_we = 1'b1;
                hp_wa = pos_reg;
                if (r_ok && r_w < ((l_ok && l_w < cur_w) ? l_w : cur_w))
                begin
                    hp_wd      = hp_rd;
                    pos_next   = r_pos[HA-1:0];
                    state_next = ST_SD_RL;
                end
                else if (l_ok && l_w < cur_w)
                begin
                    hp_wd      = lval_reg;
                    pos_next   = l_pos[HA-1:0];
                    state_next = ST_SD_RL;
                end
                else
                begin
                    hp_wd = cur_reg;
                    case (ret_reg)
                        RET_BUILD:
                        begin
                            if (bi_reg == '0)
                            begin
                                state_next = ST_MERGE;
                            end
                            else
                            begin
                                bi_next    = bi_reg - HA'(1);
                                state_next = ST_B_RD;
                            end
                        end
                        RET_A:
                        begin
                            a_next     = top_reg;
                            ret_next   = RET_B;
                            state_next = ST_T_RD0;
                        end
                        RET_B:
                        begin
                            b_next     = top_reg;
                            state_next = ST_NEW;
                        end
                        default:
                        begin
                            state_next = ST_W_INIT;
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                ret_next   = (cnt_reg > (HA+1)'(1)) ? RET_A : RET_ROOT;
                state_next = ST_T_RD0;
            end
            // take the minimum: top out, last entry moves to the top
            ST_T_RD0:
            begin
                hp_re      = 1'b1;
                hp_ra      = '0;
                state_next = ST_T_RDL;
            end
            ST_T_RDL:
            begin
                hp_re      = 1'b1;
                hp_ra      = HA'(cnt_reg - (HA+1)'(1));
                top_next   = hp_rd;
                state_next = ST_T_GO;
            end
            ST_T_GO:
            begin
                cur_next   = hp_rd;
                cnt_next   = cnt_reg - (HA+1)'(1);
                pos_next   = '0;
                state_next = ST_SD_RL;
            end
            // new internal node, then sift up into the heap
            ST_NEW:
            begin
                lk_we      = 1'b1;
                new_next   = {a_reg[HEW-1:NA] + b_reg[HEW-1:NA], nodes_reg};
                nodes_next = nodes_reg + NA'(1);
                pi_next    = cnt_reg[HA-1:0];
                cnt_next   = cnt_reg + (HA+1)'(1);
                state_next = ST_PU_RD;
            end
            ST_PU_RD:
            begin
                if (pi_reg == '0)
                begin
                    hp_we      = 1'b1;
                    hp_wa      = '0;
                    hp_wd      = new_reg;
                    state_next = ST_MERGE;
                end
                else
                begin
                    hp_re      = 1'b1;
                    hp_ra      = parent;
                    state_next = ST_PU_CMP;
                end
            end
            ST_PU_CMP:
            begin
                hp_we = 1'b1;
                hp_wa = pi_reg;
                if (new_reg[HEW-1:NA] < hp_rd[HEW-1:NA])
                begin
                    hp_wd      = hp_rd;
                    pi_next    = parent;
                    state_next = ST_PU_RD;
                end
                else
                begin
                    hp_wd      = new_reg;
                    state_next = ST_MERGE;
                end
            end
            // depth-first walk on the stack RAM
            ST_W_INIT:
            begin
                st_we      = 1'b1;
                st_wa      = '0;
                st_wd      = {top_reg[NA-1:0], {HA{1'b0}}, {CODE_W{1'b0}}};
                sp_next    = (HA+1)'(1);
                state_next = ST_W_POP;
            end
            ST_W_POP:
            begin
                if (sp_reg == '0)
                begin
                    loaded_next = '0;
                    cnt_next    = '0;
                    nodes_next  = '0;
                    state_next  = ST_LOAD;
                end
                else
                begin
                    st_re      = 1'b1;
                    sp_next    = sp_reg - (HA+1)'(1);
                    state_next = ST_W_GET;
                end
            end
            ST_W_GET:
            begin
                ent_next = st_rd;
                if (st_rd[SEW-1:HA+CODE_W] < n_reg)
                begin
                    sym_re     = 1'b1;
                    sym_ra     = st_rd[HA+CODE_W+HA-1:HA+CODE_W];
                    state_next = ST_W_EMIT;
                end
                else
                begin
                    lk_re      = 1'b1;
                    lk_ra      = st_rd[SEW-1:HA+CODE_W];
                    state_next = ST_W_LNK;
                end
            end
            ST_W_LNK:
            begin
                st_we      = 1'b1;
                st_wd      = {lk_rd[NA-1:0], HA'(e_depth + HA'(1)),
                              e_code[CODE_W-2:0], 1'b1};
                sp_next    = sp_reg + (HA+1)'(1);
                state_next = ST_W_PSH2;
            end
            ST_W_PSH2:
            begin
                st_we      = 1'b1;
                st_wd      = {lk_rd[LKW-1:NA], HA'(e_depth + HA'(1)),
                              e_code[CODE_W-2:0], 1'b0};
                sp_next    = sp_reg + (HA+1)'(1);
                state_next = ST_W_POP;
            end
            ST_W_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    od_next.code_symbol = sym_rd;
                    od_next.code_bits   = e_code;
                    od_next.code_length = len_full[LEN_W-1:0];
                    od_next.last_code   = (sp_reg == '0);
                    ov_next             = 1'b1;
                    state_next          = ST_W_POP;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            ret_reg    <= RET_BUILD;
            loaded_reg <= '0;
            n_reg      <= '0;
            cnt_reg    <= '0;
            nodes_reg  <= '0;
            bi_reg     <= '0;
            pos_reg    <= '0;
            pi_reg     <= '0;
            sp_reg     <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            loaded_reg <= loaded_next;
            n_reg      <= n_next;
            cnt_reg    <= cnt_next;
            nodes_reg  <= nodes_next;
            bi_reg     <= bi_next;
            pos_reg    <= pos_next;
            pi_reg     <= pi_next;
            sp_reg     <= sp_next;
            ov_reg     <= ov_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        lval_reg <= lval_next;
        top_reg  <= top_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        new_reg  <= new_next;
        ent_reg  <= ent_next;
        od_reg   <= od_next;
    end

    // a take never starts on an empty heap
    `HCB_ASSERT_IMPL(a_take_nonempty, state_reg == ST_T_RD0, cnt_reg != '0)
    // an emitted leaf is always one of the loaded entries
    `HCB_ASSERT_IMPL(a_emit_leaf, state_reg == ST_W_EMIT, e_node < n_reg)
    // finishing the walk clears the load count
    `HCB_ASSERT_NEXT(a_walk_end, state_reg == ST_W_POP && sp_reg == '0,
        loaded_reg == '0 && state_reg == ST_LOAD)
endmodule
`default_nettype wire

/* design/hcb_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module hcb_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire
